// File: hdl/dqc_pkg.sv
`timescale 1ns / 1ps
// Package for the deque with cursor: command and result beat types, opcodes.
// No dependencies.
package dqc_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned FILL_W = 5;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_CUR_HEAD   = 3'd4,
        OP_CUR_TAIL   = 3'd5,
        OP_READ_NEXT  = 3'd6,
        OP_READ_PREV  = 3'd7
    } opcode_t;

    typedef struct packed {
        opcode_t             opcode;
        logic [DATA_W-1:0]   push_value;
    } cmd_t;

    typedef struct packed {
        logic [DATA_W-1:0]   out_value;
        logic                out_valid;
        logic                is_empty;
        logic [FILL_W-1:0]   fill_count;
        logic                overflow;
    } result_t;

endpackage

// File: hdl/deque_with_cursor_top.sv
`timescale 1ns / 1ps
// Bounded deque of handles in a ring memory, with one read cursor.
// Depends on dqc_pkg.
//
//  channel  | ports                | handshake
//  ---------+----------------------+-------------------------------------
//  command  | start, busy, cmd     | beat taken at clk edge: start & !busy
//  result   | done, result         | one beat per command, done for 1 cycle
//
// One command per cycle; busy stays low. The result beat of a command shows
// in the cycle after its acceptance edge, set by the registered
// read of the slot memory. Pointers and writes update at the acceptance edge,
// so a following command sees them at once. Reset clears pointers, count and
// cursor; the slot memory is not cleared. The receiver cannot stall.
module deque_with_cursor_top
    import dqc_pkg::*;
#(
    parameter int unsigned DEPTH = 16
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  cmd_t    cmd,
    output logic    done,
    output result_t result
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    // ring index helpers
    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a,
                                               input logic [AW-1:0] b);
        logic [AW:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= (AW+1)'(DEPTH))
            sum = sum - (AW+1)'(DEPTH);
        return sum[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] i);
        return (i == AW'(DEPTH - 1)) ? '0 : i + AW'(1);
    endfunction

    function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] i);
        return (i == '0) ? AW'(DEPTH - 1) : i - AW'(1);
    endfunction

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] cur_reg, cur_next;
    logic          cur_live_reg, cur_live_next;
    logic          done_reg;
    logic          valid_reg, valid_next;
    logic          ovf_reg, ovf_next;

    logic          accept;
    logic          full, empty;
    logic [AW-1:0] tail;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign full   = (count_reg == CW'(DEPTH));
    assign empty  = (count_reg == '0);
    assign tail   = wrap_add(head_reg, AW'(count_reg - CW'(1)));

    // operation decode and pointer update
    always_comb
    begin
        head_next     = head_reg;
        count_next    = count_reg;
        cur_next      = cur_reg;
        cur_live_next = cur_live_reg;
        valid_next    = 1'b0;
        ovf_next      = 1'b0;
        wr_en         = 1'b0;
        wr_addr       = head_reg;
        rd_addr       = head_reg;
        if (accept)
        begin
            unique case (cmd.opcode) inside
                OP_PUSH_FRONT:
                begin
                    if (full)
                        ovf_next = 1'b1;
                    else
                    begin
                        head_next  = wrap_dec(head_reg);
                        wr_en      = 1'b1;
                        wr_addr    = head_next;
                        count_next = count_reg + CW'(1);
                    end
                end
                OP_PUSH_BACK:
                begin
                    if (full)
                        ovf_next = 1'b1;
                    else
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = wrap_add(head_reg, AW'(count_reg));
                        count_next = count_reg + CW'(1);
                    end
                end
                OP_POP_FRONT, OP_POP_BACK:
                begin
                    if (!empty)
                    begin
                        rd_addr = (cmd.opcode == OP_POP_FRONT) ? head_reg : tail;
                        if (cur_live_reg && cur_reg == rd_addr)
                            cur_live_next = 1'b0;
                        valid_next = 1'b1;
                        if (cmd.opcode == OP_POP_FRONT)
                            head_next = wrap_inc(head_reg);
                        count_next = count_reg - CW'(1);
                    end
                end
                OP_CUR_HEAD, OP_CUR_TAIL:
                begin
                    if (empty)
                        cur_live_next = 1'b0;
                    else
                    begin
                        cur_next      = (cmd.opcode == OP_CUR_HEAD) ? head_reg : tail;
                        cur_live_next = 1'b1;
                    end
                end
                OP_READ_NEXT, OP_READ_PREV:
                begin
                    if (cur_live_reg && !empty)
                    begin
                        rd_addr    = cur_reg;
                        valid_next = 1'b1;
                        if (cmd.opcode == OP_READ_NEXT)
                        begin
                            if (cur_reg == tail)
                                cur_live_next = 1'b0;
                            else
                                cur_next = wrap_inc(cur_reg);
                        end
                        else
                        begin
                            if (cur_reg == head_reg)
                                cur_live_next = 1'b0;
                            else
                                cur_next = wrap_dec(cur_reg);
                        end
                    end
                end
                default:
                begin
                    ovf_next = 1'b0;
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg     <= '0;
            count_reg    <= '0;
            cur_reg      <= '0;
            cur_live_reg <= 1'b0;
            done_reg     <= 1'b0;
            valid_reg    <= 1'b0;
            ovf_reg      <= 1'b0;
        end
        else
        begin
            head_reg     <= head_next;
            count_reg    <= count_next;
            cur_reg      <= cur_next;
            cur_live_reg <= cur_live_next;
            done_reg     <= accept;
            valid_reg    <= valid_next;
            ovf_reg      <= ovf_next;
        end
    end

    // slot memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= cmd.push_value;
        rd_data_reg <= mem[rd_addr];
    end

    // result beat
    assign done              = done_reg;
    assign result.out_value  = valid_reg ? rd_data_reg : '0;
    assign result.out_valid  = valid_reg;
    assign result.is_empty   = empty;
    assign result.fill_count = FILL_W'(count_reg);
    assign result.overflow   = ovf_reg;

endmodule
